@@ hw/rtl/sttmp_pkg.sv @@
// Shared types, constants and codes for the servo trapezoid motion profile block.
package sttmp_pkg;

   localparam int MUL_W = 26;
   localparam int PROD_W = 2 * MUL_W;
   localparam int NUM_W = 48;
   localparam int DEN_W = 18;

   localparam logic [16:0] Q_ONE = 17'd65536;
   localparam logic [24:0] SNAP_SPEED = 25'd6554;
   localparam logic [17:0] SNAP_DIST = 18'd328;

   typedef enum logic [2:0] {
      CSR_PWM_LOW  = 3'd0,
      CSR_PWM_HIGH = 3'd1,
      CSR_TOP      = 3'd2,
      CSR_ACCEL    = 3'd3,
      CSR_TICK     = 3'd4,
      CSR_ENGAGED  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_ACCEL  = 2'd1,
      PHASE_CRUISE = 2'd2,
      PHASE_DECEL  = 2'd3
   } motion_phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_VV,
      ST_NEED,
      ST_DECIDE,
      ST_NV,
      ST_ACC,
      ST_MACC,
      ST_MDEC,
      ST_MPOS,
      ST_STOP,
      ST_WIDTH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quo;
   } div_rsp_type;

   function automatic logic near_stop(input logic [24:0] v_mag, input logic [17:0] d_mag);
      return (v_mag < SNAP_SPEED) && (d_mag < SNAP_DIST);
   endfunction

endpackage

@@ hw/rtl/sttmp_mul.sv @@
// Bit-serial shift-add unsigned multiplier, one multiplier bit per cycle.
module sttmp_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  sttmp_pkg::mul_req_type mul_req,
   output sttmp_pkg::mul_rsp_type mul_rsp
);
   import sttmp_pkg::*;

   localparam int CNT_W = $clog2(MUL_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_W - 1);

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [MUL_W-1:0]  a_ff, a_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [MUL_W:0]    sum;

   always_comb begin
      prod_in = prod_ff;
      a_in = a_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sum = {1'b0, prod_ff[PROD_W-1:MUL_W]} + (prod_ff[0] ? {1'b0, a_ff} : '0);
      if (mul_req.start) begin
         prod_in = {{MUL_W{1'b0}}, mul_req.b};
         a_in = mul_req.a;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[MUL_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      prod_ff <= prod_in;
      a_ff <= a_in;
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.prod = prod_ff;

endmodule

@@ hw/rtl/sttmp_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module sttmp_div (
   input  logic                  clock,
   input  logic                  reset,
   input  sttmp_pkg::div_req_type div_req,
   output sttmp_pkg::div_rsp_type div_rsp
);
   import sttmp_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W+1:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {1'b0, rem_ff, quo_ff[NUM_W-1]} - {2'b00, den_ff};
      if (div_req.start) begin
         quo_in = div_req.num;
         rem_in = '0;
         den_in = div_req.den;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DEN_W+1]) begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DEN_W-2:0], quo_ff[NUM_W-1]};
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo = quo_ff;

endmodule

@@ hw/rtl/servo_trapezoid_motion_profile_top.sv @@
// Top level of the servo trapezoid motion profile block: sequencer and axis state.
//
// One item per tick on req_: target_pos (Q1.16, clamped to 1.0) and hold.
// One result per item on rsp_: pulse_width, width_changed, motion_phase, position.
// csr_ writes the six registers by index; csr_ready is always high and writes
// take effect at once, so they belong to idle periods.
// req_stall is high while an item is in work; the next item is taken the cycle
// after the result has been placed in the output register.
// A held item goes straight to the output state, which loads the output register.
// A moving item runs a serial multiplier and a 48-step divider in sequence: v*v
// on the multiplier, the deceleration estimate on the divider when the distance
// is nonzero, a decide state, two divisions and a multiplication on the
// accelerate path or one multiplication on the decelerate path, a multiplication
// for the position update, a snap onto the target when near a stop, the width
// on the multiplier (skipped when disengaged) and the load of the output.
// rsp_valid stays high with the payload held while rsp_stall is high; a
// finished item then waits in the sequencer and stalls the input side.
// Reset is synchronous: registers return to their defaults, position and
// speed to zero, phase to idle and the last width to one.
module servo_trapezoid_motion_profile_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [16:0] req_target_pos,
   input  logic        req_hold,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_pulse_width,
   output logic        rsp_width_changed,
   output logic [1:0]  rsp_motion_phase,
   output logic [16:0] rsp_position,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);
   import sttmp_pkg::*;

   state_type   state_ff, state_in;
   logic        launch_ff;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [11:0] low_ff, high_ff;
   logic [23:0] top_ff, alim_ff;
   logic [15:0] tick_ff;
   logic        engaged_ff;

   logic [16:0] pos_ff, pos_in;
   logic [24:0] speed_ff, speed_in;
   logic [1:0]  phase_ff, phase_in;
   logic [11:0] last_width_ff, last_width_in;
   logic [16:0] target_ff, target_in;
   logic [15:0] dt_ff, dt_in;
   logic [17:0] dist_ff, dist_in;
   logic [24:0] need_ff, need_in;
   logic [33:0] diff_ff, diff_in;
   logic [24:0] acc_mag_ff, acc_mag_in;
   logic        acc_neg_ff, acc_neg_in;
   logic [11:0] res_width_ff, res_width_in;
   logic        res_changed_ff, res_changed_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [11:0] rsp_width_ff, rsp_width_in;
   logic        rsp_changed_ff, rsp_changed_in;
   logic [1:0]  rsp_phase_ff, rsp_phase_in;
   logic [16:0] rsp_pos_ff, rsp_pos_in;

   logic        v_neg, d_neg, diff_neg, add_neg, ns_neg, w_neg;
   logic [24:0] v_mag, lim;
   logic [17:0] d_mag, dist2, d2_mag;
   logic [33:0] diff_mag, nv;
   logic [25:0] p_step;
   logic [27:0] v_ext, p_ext, ns, ns_mag, np;
   logic [16:0] new_pos, tgt_clamp;
   logic [12:0] w_diff, w_mag, r;
   logic [28:0] rnd;
   logic [13:0] w_sum;

   sttmp_mul u_mul (.clock(clock), .reset(reset), .mul_req(mul_req), .mul_rsp(mul_rsp));
   sttmp_div u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff <= 12'd1300;
         high_ff <= 12'd1700;
         top_ff <= 24'd21845;
         alim_ff <= 24'd24272;
         tick_ff <= 16'd1311;
         engaged_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PWM_LOW: low_ff <= csr_data[11:0];
            CSR_PWM_HIGH: high_ff <= csr_data[11:0];
            CSR_TOP: top_ff <= csr_data;
            CSR_ACCEL: alim_ff <= csr_data;
            CSR_TICK: tick_ff <= csr_data[15:0];
            CSR_ENGAGED: engaged_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         launch_ff <= 1'b0;
         pos_ff <= '0;
         speed_ff <= '0;
         phase_ff <= PHASE_IDLE;
         last_width_ff <= 12'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         launch_ff <= (state_in != state_ff);
         pos_ff <= pos_in;
         speed_ff <= speed_in;
         phase_ff <= phase_in;
         last_width_ff <= last_width_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      target_ff <= target_in;
      dt_ff <= dt_in;
      dist_ff <= dist_in;
      need_ff <= need_in;
      diff_ff <= diff_in;
      acc_mag_ff <= acc_mag_in;
      acc_neg_ff <= acc_neg_in;
      res_width_ff <= res_width_in;
      res_changed_ff <= res_changed_in;
      rsp_width_ff <= rsp_width_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_pos_ff <= rsp_pos_in;
   end

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      speed_in = speed_ff;
      phase_in = phase_ff;
      last_width_in = last_width_ff;
      target_in = target_ff;
      dt_in = dt_ff;
      dist_in = dist_ff;
      need_in = need_ff;
      diff_in = diff_ff;
      acc_mag_in = acc_mag_ff;
      acc_neg_in = acc_neg_ff;
      res_width_in = res_width_ff;
      res_changed_in = res_changed_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_width_in = rsp_width_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_phase_in = rsp_phase_ff;
      rsp_pos_in = rsp_pos_ff;
      mul_req = '0;
      div_req = '0;

      v_neg = speed_ff[24];
      v_mag = v_neg ? 25'd0 - speed_ff : speed_ff;
      d_neg = dist_ff[17];
      d_mag = d_neg ? 18'd0 - dist_ff : dist_ff;
      lim = {alim_ff, 1'b0};
      diff_neg = diff_ff[33];
      diff_mag = diff_neg ? 34'd0 - diff_ff : diff_ff;
      nv = d_neg ? 34'd0 - {1'b0, div_rsp.quo[32:0]} : {1'b0, div_rsp.quo[32:0]};
      p_step = mul_rsp.prod[41:16];
      v_ext = {{3{speed_ff[24]}}, speed_ff};
      p_ext = {2'b00, p_step};
      add_neg = 1'b0;
      case (state_ff)
         ST_MACC: add_neg = acc_neg_ff;
         ST_MDEC: add_neg = !d_neg && (dist_ff != 18'd0);
         default: add_neg = 1'b0;
      endcase
      ns = add_neg ? v_ext - p_ext : v_ext + p_ext;
      ns_neg = ns[27];
      ns_mag = ns_neg ? 28'd0 - ns : ns;
      np = v_neg ? {11'd0, pos_ff} - p_ext : {11'd0, pos_ff} + p_ext;
      if (np[27])
         new_pos = '0;
      else if (np > {11'd0, Q_ONE})
         new_pos = Q_ONE;
      else
         new_pos = np[16:0];
      dist2 = {1'b0, target_ff} - {1'b0, new_pos};
      d2_mag = dist2[17] ? 18'd0 - dist2 : dist2;
      tgt_clamp = (req_target_pos > Q_ONE) ? Q_ONE : req_target_pos;
      w_diff = {1'b0, high_ff} - {1'b0, low_ff};
      w_neg = w_diff[12];
      w_mag = w_neg ? 13'd0 - w_diff : w_diff;
      rnd = mul_rsp.prod[28:0] + 29'd32768;
      r = rnd[28:16];
      w_sum = w_neg ? {2'b00, low_ff} - {1'b0, r} : {2'b00, low_ff} + {1'b0, r};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               target_in = tgt_clamp;
               dt_in = (tick_ff == 16'd0) ? 16'd1 : tick_ff;
               dist_in = {1'b0, tgt_clamp} - {1'b0, pos_ff};
               if (req_hold) begin
                  res_width_in = last_width_ff;
                  res_changed_in = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_VV;
               end
            end
         end
         ST_VV: begin
            mul_req.start = launch_ff;
            mul_req.a = {1'b0, v_mag};
            mul_req.b = {1'b0, v_mag};
            if (mul_rsp.done) begin
               need_in = '0;
               state_in = (dist_ff == 18'd0) ? ST_DECIDE : ST_NEED;
            end
         end
         ST_NEED: begin
            div_req.start = launch_ff;
            div_req.num = mul_rsp.prod[47:0];
            div_req.den = {d_mag[16:0], 1'b0};
            if (div_rsp.done) begin
               need_in = (div_rsp.quo > {23'd0, lim}) ? lim : div_rsp.quo[24:0];
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (near_stop(v_mag, d_mag))
               state_in = ST_STOP;
            else if ((d_neg != v_neg) || (need_ff < {1'b0, alim_ff}))
               state_in = ST_NV;
            else
               state_in = ST_MDEC;
         end
         ST_NV: begin
            div_req.start = launch_ff;
            div_req.num = {15'd0, d_mag[16:0], 16'd0};
            div_req.den = {1'b0, dt_ff, 1'b0};
            if (div_rsp.done) begin
               diff_in = nv - {{9{speed_ff[24]}}, speed_ff};
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            div_req.start = launch_ff;
            div_req.num = {diff_mag[31:0], 16'd0};
            div_req.den = {2'b00, dt_ff};
            if (div_rsp.done) begin
               if (div_rsp.quo >= {24'd0, alim_ff}) begin
                  acc_mag_in = {1'b0, alim_ff};
                  acc_neg_in = d_neg;
               end else begin
                  acc_mag_in = div_rsp.quo[24:0];
                  acc_neg_in = diff_neg;
               end
               state_in = ST_MACC;
            end
         end
         ST_MACC: begin
            mul_req.start = launch_ff;
            mul_req.a = {1'b0, acc_mag_ff};
            mul_req.b = {10'd0, dt_ff};
            if (mul_rsp.done) begin
               if (ns_mag <= {4'd0, top_ff}) begin
                  speed_in = ns[24:0];
                  phase_in = PHASE_ACCEL;
               end else begin
                  speed_in = ns_neg ? 25'd0 - {1'b0, top_ff} : {1'b0, top_ff};
                  phase_in = PHASE_CRUISE;
               end
               state_in = ST_MPOS;
            end
         end
         ST_MDEC: begin
            mul_req.start = launch_ff;
            mul_req.a = {1'b0, need_ff};
            mul_req.b = {10'd0, dt_ff};
            if (mul_rsp.done) begin
               if (ns_neg != v_neg) begin
                  state_in = ST_STOP;
               end else begin
                  speed_in = ns[24:0];
                  phase_in = PHASE_DECEL;
                  state_in = ST_MPOS;
               end
            end
         end
         ST_MPOS: begin
            mul_req.start = launch_ff;
            mul_req.a = {1'b0, v_mag};
            mul_req.b = {10'd0, dt_ff};
            if (mul_rsp.done) begin
               pos_in = new_pos;
               state_in = near_stop(v_mag, d2_mag) ? ST_STOP : ST_WIDTH;
            end
         end
         ST_STOP: begin
            phase_in = PHASE_IDLE;
            speed_in = '0;
            pos_in = target_ff;
            state_in = ST_WIDTH;
         end
         ST_WIDTH: begin
            mul_req.start = launch_ff && engaged_ff;
            mul_req.a = {13'd0, w_mag};
            mul_req.b = {9'd0, pos_ff};
            if (!engaged_ff) begin
               res_width_in = '0;
               res_changed_in = (last_width_ff != 12'd0);
               last_width_in = '0;
               state_in = ST_OUT;
            end else if (mul_rsp.done) begin
               res_width_in = w_sum[11:0];
               res_changed_in = (w_sum[11:0] != last_width_ff);
               last_width_in = w_sum[11:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_width_in = res_width_ff;
               rsp_changed_in = res_changed_ff;
               rsp_phase_in = phase_ff;
               rsp_pos_in = pos_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pulse_width = rsp_width_ff;
   assign rsp_width_changed = rsp_changed_ff;
   assign rsp_motion_phase = rsp_phase_ff;
   assign rsp_position = rsp_pos_ff;

endmodule

@@ tb/testbench.sv @@
// Testbench for the servo trapezoid motion profile block: scoreboard, stimulus, checks.
`timescale 1ns / 100ps

module testbench;
   import sttmp_pkg::*;

   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic [11:0] pulse_width;
      logic        width_changed;
      logic [1:0]  motion_phase;
      logic [16:0] position;
   } axis_result_type;

   class axis_scoreboard;
      longint pwm_low, pwm_high, top_speed, accel_limit, tick, engaged;
      longint pos, spd;
      logic [1:0]  phase;
      logic [11:0] last_width;
      axis_result_type pending[$];
      int errors;

      function new();
         pwm_low = 1300; pwm_high = 1700; top_speed = 21845;
         accel_limit = 24272; tick = 1311; engaged = 1;
         pos = 0; spd = 0; phase = PHASE_IDLE; last_width = 12'd1; errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [23:0] d);
         case (idx)
            CSR_PWM_LOW:  pwm_low = d[11:0];
            CSR_PWM_HIGH: pwm_high = d[11:0];
            CSR_TOP:      top_speed = d;
            CSR_ACCEL:    accel_limit = d;
            CSR_TICK:     tick = d[15:0];
            CSR_ENGAGED:  engaged = d[0];
            default: ;
         endcase
      endfunction

      function longint mag(longint x);
         return x < 0 ? -x : x;
      endfunction

      function longint div_trunc(longint n, longint d);
         longint q;
         q = mag(n) / d;
         return n < 0 ? -q : q;
      endfunction

      function longint mul_tick(longint a, longint b);
         longint p;
         p = (mag(a) * b) >> 16;
         return a < 0 ? -p : p;
      endfunction

      function bit settled(longint v, longint d);
         return mag(v) < longint'(SNAP_SPEED) && mag(d) < longint'(SNAP_DIST);
      endfunction

      function void note_item(logic [16:0] tgt, logic hold);
         axis_result_type r;
         longint target, dt, v, dpos, need, m, nv, acc, ns, p, num, rw;
         bit stop, reverse;
         target = tgt > 17'd65536 ? 65536 : tgt;
         dt = tick != 0 ? tick : 1;
         v = spd;
         stop = 0;
         if (hold) begin
            r.pulse_width = last_width;
            r.width_changed = 0;
            r.motion_phase = phase;
            r.position = pos;
            pending.push_back(r);
            return;
         end
         dpos = target - pos;
         need = 0;
         if (dpos != 0) begin
            m = (mag(v) * mag(v)) / (2 * mag(dpos));
            if (m > 2 * accel_limit) m = 2 * accel_limit;
            need = dpos > 0 ? -m : m;
         end
         reverse = (dpos < 0) != (v < 0);
         if (settled(v, dpos)) begin
            stop = 1;
         end else if (reverse || mag(need) < accel_limit) begin
            nv = div_trunc(dpos * 65536, 2 * dt);
            acc = div_trunc((nv - v) * 65536, dt);
            if (mag(acc) >= accel_limit) acc = dpos < 0 ? -accel_limit : accel_limit;
            ns = v + mul_tick(acc, dt);
            if (mag(ns) <= top_speed) begin
               spd = ns; phase = PHASE_ACCEL;
            end else begin
               spd = ns < 0 ? -top_speed : top_speed; phase = PHASE_CRUISE;
            end
         end else begin
            ns = v + mul_tick(need, dt);
            if ((ns < 0) != (v < 0)) stop = 1;
            else begin
               spd = ns; phase = PHASE_DECEL;
            end
         end
         if (!stop) begin
            p = pos + mul_tick(spd, dt);
            if (p < 0) p = 0;
            if (p > 65536) p = 65536;
            pos = p;
            if (settled(spd, target - p)) stop = 1;
         end
         if (stop) begin
            phase = PHASE_IDLE; spd = 0; pos = target;
         end
         if (engaged != 0) begin
            num = (pwm_high - pwm_low) * pos;
            rw = (mag(num) + 32768) >> 16;
            if (num < 0) rw = -rw;
            r.pulse_width = 12'(pwm_low + rw);
         end else begin
            r.pulse_width = 12'd0;
         end
         r.width_changed = r.pulse_width != last_width;
         r.motion_phase = phase;
         r.position = pos;
         last_width = r.pulse_width;
         pending.push_back(r);
      endfunction

      function void check_result(axis_result_type got);
         axis_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected result item");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.pulse_width !== e.pulse_width) begin
            $error("pulse_width exp %0d got %0d", e.pulse_width, got.pulse_width); errors++;
         end
         if (got.width_changed !== e.width_changed) begin
            $error("width_changed exp %0d got %0d", e.width_changed, got.width_changed);
            errors++;
         end
         if (got.motion_phase !== e.motion_phase) begin
            $error("motion_phase exp %0d got %0d", e.motion_phase, got.motion_phase); errors++;
         end
         if (got.position !== e.position) begin
            $error("position exp %0d got %0d", e.position, got.position); errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [16:0] req_target_pos = '0;
   logic        req_hold = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_pulse_width;
   logic        rsp_width_changed;
   logic [1:0]  rsp_motion_phase;
   logic [16:0] rsp_position;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_data = '0;

   axis_scoreboard axis_sb = new();
   bit  quiet = 0;
   int  stall_mode = 0;
   int  idle_cycles = 0;

   servo_trapezoid_motion_profile_top uut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      axis_result_type got;
      if (!reset) begin
         if (req_valid && !req_stall) axis_sb.note_item(req_target_pos, req_hold);
         if (rsp_valid && !rsp_stall) begin
            got.pulse_width = rsp_pulse_width;
            got.width_changed = rsp_width_changed;
            got.motion_phase = rsp_motion_phase;
            got.position = rsp_position;
            axis_sb.check_result(got);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_valid)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // receiver backpressure; mode picks none, light or heavy stalling
   always @(posedge clock) begin
      if ($urandom_range(0, 399) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         1: rsp_stall <= $urandom_range(0, 3) == 0;
         2: rsp_stall <= $urandom_range(0, 15) != 0;
         default: rsp_stall <= 1'b0;
      endcase
   end

   function int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(20, 80);
   endfunction

   task send_item(logic [16:0] tgt, logic hold);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_target_pos <= tgt;
      req_hold <= hold;
      do @(posedge clock); while (req_stall);
   endtask

   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (axis_sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_reg(csr_index_type idx, logic [23:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      axis_sb.set_reg(idx, d);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task load_regs(int lo, int hi, int top, int acc, int tk, int en);
      drain();
      write_reg(CSR_PWM_LOW, lo);
      write_reg(CSR_PWM_HIGH, hi);
      write_reg(CSR_TOP, top);
      write_reg(CSR_ACCEL, acc);
      write_reg(CSR_TICK, tk);
      write_reg(CSR_ENGAGED, en);
   endtask

   task move_to(logic [16:0] tgt, int ticks);
      repeat (ticks) send_item(tgt, $urandom_range(0, 9) == 0);
   endtask

   initial begin
      int n, sel;
      logic [16:0] tgt;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: defaults, clamp, hold, snap, reversal
      send_item(17'd0, 1'b0);
      send_item(17'd0, 1'b1);
      send_item(17'd200, 1'b0);
      send_item(17'h1FFFF, 1'b0);
      send_item(17'd65536, 1'b0);
      send_item(17'd65536, 1'b1);
      send_item(17'd0, 1'b0);
      send_item(17'd65535, 1'b0);
      send_item(17'd1, 1'b0);
      load_regs(4000, 0, 16777215, 16777215, 65535, 1);
      send_item(17'd65536, 1'b0);
      send_item(17'd0, 1'b0);
      send_item(17'd32768, 1'b0);
      load_regs(0, 4000, 0, 0, 0, 0);
      send_item(17'd50000, 1'b0);
      send_item(17'd100, 1'b0);
      send_item(17'd100, 1'b1);
      load_regs(4095, 4095, 1, 16777215, 1, 1);
      send_item(17'd65536, 1'b0);
      send_item(17'd0, 1'b0);
      load_regs(1000, 2000, 300000, 2000000, 6000, 1);
      send_item(17'd60000, 1'b0);
      send_item(17'd60000, 1'b0);
      send_item(17'd10000, 1'b0);
      send_item(17'd10000, 1'b0);

      n = 0;
      while (n < 1250) begin
         sel = $urandom_range(0, 5);
         case (sel)
            0: load_regs(1300, 1700, 21845, 24272, 1311, 1);
            1: load_regs(0, 4000, 16777215, 16777215, 65535, 1);
            2: load_regs($urandom_range(0, 4000), $urandom_range(0, 4000),
                         $urandom_range(1, 16777215), $urandom_range(1, 16777215),
                         $urandom_range(1, 65535), $urandom_range(0, 1));
            default: load_regs($urandom_range(0, 4095), $urandom_range(0, 4095),
                               $urandom_range(5000, 800000), $urandom_range(5000, 4000000),
                               $urandom_range(300, 8000), $urandom_range(0, 7) != 0);
         endcase
         quiet = $urandom_range(0, 3) == 0;
         repeat (12) begin
            int ticks;
            if ($urandom_range(0, 9) == 0) tgt = $urandom_range(0, 131071);
            else if ($urandom_range(0, 5) == 0) tgt = $urandom_range(0, 1) ? 17'd65536 : 17'd0;
            else tgt = $urandom_range(0, 65536);
            ticks = $urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 20);
            move_to(tgt, ticks);
            n += ticks;
         end
      end

      req_valid <= 1'b0;
      while (axis_sb.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (axis_sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/sttmp_pkg.sv
hw/rtl/sttmp_mul.sv
hw/rtl/sttmp_div.sv
hw/rtl/servo_trapezoid_motion_profile_top.sv
tb/testbench.sv
